/* src/qte_pkg.sv */
// Shared types, constants and arithmetic helpers for the quaternion to Euler angle converter.
// Depends on nothing; every other file in src imports it.
package qte_pkg;

    // Width of the CORDIC x/y datapath and of the angle accumulator (Q16 degrees).
    localparam int CW = 37;
    localparam int ZW = 27;
    localparam int ATAN_LEN = 24;

    typedef logic signed [CW-1:0] cord_val_t;
    typedef logic signed [ZW-1:0] ang_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_in_t;

    typedef struct packed {
        logic signed [14:0] yaw_deg;
        logic signed [15:0] pitch_deg;
        logic signed [15:0] roll_deg;
        logic [1:0]         status;
    } euler_out_t;

    typedef struct packed {
        cord_val_t x;
        cord_val_t y;
        ang_t      z;
        logic      org;
    } lane_t;

    typedef struct packed {
        logic zero;
        logic sat;
        logic neg;
    } flags_t;

    typedef struct packed {
        flags_t      flags;
        logic [30:0] mp;
        lane_t       pitch;
        lane_t       roll;
    } sq_side_t;

    typedef struct packed {
        flags_t flags;
        lane_t  yaw;
        lane_t  pitch;
        lane_t  roll;
    } cord_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam ang_t HALF_TURN    = 27'sd11796480;
    localparam ang_t QUARTER_TURN = 27'sd5898240;

    // atan(2^-i) in degrees, Q16.
    function automatic ang_t atan_q16(input int i);
        ang_t r;
        unique case (i)
            0:  r = 27'sd2949120;
            1:  r = 27'sd1740967;
            2:  r = 27'sd919879;
            3:  r = 27'sd466945;
            4:  r = 27'sd234379;
            5:  r = 27'sd117304;
            6:  r = 27'sd58666;
            7:  r = 27'sd29335;
            8:  r = 27'sd14668;
            9:  r = 27'sd7334;
            10: r = 27'sd3667;
            11: r = 27'sd1833;
            12: r = 27'sd917;
            13: r = 27'sd458;
            14: r = 27'sd229;
            15: r = 27'sd115;
            16: r = 27'sd57;
            17: r = 27'sd29;
            18: r = 27'sd14;
            19: r = 27'sd7;
            20: r = 27'sd4;
            21: r = 27'sd2;
            22: r = 27'sd1;
            default: r = 27'sd0;
        endcase
        return r;
    endfunction

    // One vectoring micro-rotation, driving y towards zero.
    function automatic lane_t cordic_step(input lane_t l, input int i);
        lane_t     r;
        cord_val_t dx;
        cord_val_t dy;
        dx = l.y >>> i;
        dy = l.x >>> i;
        r  = l;
        if (!l.y[CW-1]) begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + atan_q16(i);
        end else begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - atan_q16(i);
        end
        return r;
    endfunction

endpackage

/* src/quaternion_to_euler_angles.sv */
// Pipeline: five front-end stages, 31 square-root stages (one root bit each), CORDIC_STAGES
// micro-rotations and one output register.
// Throughput: one request per cycle while m_ready stays high; every stage holds its own valid bit
// and only stalls while the stage after it is full, so bubbles close up behind a stalled result.
// Reset: synchronous, active low on aresetn; clears all valid bits, no data is cleared.
// Depends on qte_pkg and the qte_front, qte_isqrt, qte_cordic and qte_back modules.
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  quat_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output euler_out_t m_data
);

    // The front end forms the squared norm, the rotation matrix terms for the two atan2 angles
    // and the radicand n'^2 - m'^2 whose root is the cosine side of the asin triangle.
    logic        fr_valid, fr_ready;
    logic [61:0] fr_rad;
    sq_side_t    fr_side;

    qte_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (fr_valid),
        .m_ready (fr_ready),
        .m_rad   (fr_rad),
        .m_side  (fr_side)
    );

    // Exact floor square root; the atan2 operands ride along unchanged.
    logic        sq_valid, sq_ready;
    logic [30:0] sq_root;
    sq_side_t    sq_side;

    qte_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (fr_valid),
        .s_ready (fr_ready),
        .s_rad   (fr_rad),
        .s_side  (fr_side),
        .m_valid (sq_valid),
        .m_ready (sq_ready),
        .m_root  (sq_root),
        .m_side  (sq_side)
    );

    // The asin angle is atan2(m', root), vectored from the right half plane.
    cord_t cd_in;

    always_comb begin
        cd_in.flags     = sq_side.flags;
        cd_in.yaw.x     = {{(CW-31){1'b0}}, sq_root};
        cd_in.yaw.y     = {{(CW-31){1'b0}}, sq_side.mp};
        cd_in.yaw.z     = '0;
        cd_in.yaw.org   = 1'b0;
        cd_in.pitch     = sq_side.pitch;
        cd_in.roll      = sq_side.roll;
    end

    logic  cd_valid, cd_ready;
    cord_t cd_out;

    qte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (sq_valid),
        .s_ready (sq_ready),
        .s_data  (cd_in),
        .m_valid (cd_valid),
        .m_ready (cd_ready),
        .m_data  (cd_out)
    );

    // Rounding, clamping and status, held in the output register.
    qte_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (cd_valid),
        .s_ready (cd_ready),
        .s_data  (cd_out),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    a_zero_angles: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_ZERO) |->
        (m_data.yaw_deg == 15'sd0 && m_data.pitch_deg == 16'sd0 && m_data.roll_deg == 16'sd0))
        else $error("zero quaternion result with non-zero angle");

    a_sat_yaw: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_SAT) |->
        (m_data.yaw_deg == 15'sd11520 || m_data.yaw_deg == -15'sd11520))
        else $error("saturated asin result not at a quarter turn");

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.yaw_deg <= 15'sd11520 && m_data.yaw_deg >= -15'sd11520))
        else $error("yaw outside its range");

    a_atan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pitch_deg <= 16'sd23040 && m_data.pitch_deg >= -16'sd23040 &&
                     m_data.roll_deg <= 16'sd23040 && m_data.roll_deg >= -16'sd23040))
        else $error("atan2 angle outside its range");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_ZERO) |->
        (m_data.status == STATUS_OK || m_data.status == STATUS_SAT))
        else $error("undefined status code");
`endif

endmodule

/* src/qte_front.sv */
// Front end: component products, rotation matrix terms, normalising shift and radicand.
// Depends on qte_pkg.
module qte_front import qte_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  quat_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [61:0] m_rad,
    output sq_side_t    m_side
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;

    assign r5 = !v5_reg || m_ready;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign s_ready = r1;

    // Stage 1: the ten products.
    logic signed [31:0] ww, xx, yy, zz, yw, xz, xy, zw, yz, xw;
    assign ww = $signed(s_data.quat_w) * $signed(s_data.quat_w);
    assign xx = $signed(s_data.quat_x) * $signed(s_data.quat_x);
    assign yy = $signed(s_data.quat_y) * $signed(s_data.quat_y);
    assign zz = $signed(s_data.quat_z) * $signed(s_data.quat_z);
    assign yw = $signed(s_data.quat_y) * $signed(s_data.quat_w);
    assign xz = $signed(s_data.quat_x) * $signed(s_data.quat_z);
    assign xy = $signed(s_data.quat_x) * $signed(s_data.quat_y);
    assign zw = $signed(s_data.quat_z) * $signed(s_data.quat_w);
    assign yz = $signed(s_data.quat_y) * $signed(s_data.quat_z);
    assign xw = $signed(s_data.quat_x) * $signed(s_data.quat_w);

    logic [30:0]        sw1_reg, sx1_reg, sy1_reg, sz1_reg;
    logic signed [31:0] yw1_reg, xz1_reg, xy1_reg, zw1_reg, yz1_reg, xw1_reg;

    // Stage 2: norm and matrix terms.
    logic [32:0]        n_next;
    logic signed [33:0] num_next, py_next, ry_next;
    logic signed [32:0] px_next, rx_next;
    logic signed [32:0] esw, esx, esy, esz;

    assign esw = $signed({2'b00, sw1_reg});
    assign esx = $signed({2'b00, sx1_reg});
    assign esy = $signed({2'b00, sy1_reg});
    assign esz = $signed({2'b00, sz1_reg});
    assign n_next   = {2'b00, sw1_reg} + {2'b00, sx1_reg} + {2'b00, sy1_reg} + {2'b00, sz1_reg};
    assign num_next = {($signed({yw1_reg[31], yw1_reg}) - $signed({xz1_reg[31], xz1_reg})), 1'b0};
    assign py_next  = {($signed({xy1_reg[31], xy1_reg}) + $signed({zw1_reg[31], zw1_reg})), 1'b0};
    assign ry_next  = {($signed({yz1_reg[31], yz1_reg}) + $signed({xw1_reg[31], xw1_reg})), 1'b0};
    assign px_next  = esx - esy - esz + esw;
    assign rx_next  = esz + esw - esx - esy;

    logic [32:0]        n2_reg;
    logic signed [33:0] num2_reg, py2_reg, ry2_reg;
    logic signed [32:0] px2_reg, rx2_reg;

    // Stage 3: magnitude, saturation test, shift and half-plane folding.
    function automatic lane_t atan2_init(input logic signed [33:0] yv,
                                         input logic signed [32:0] xv);
        lane_t     l;
        cord_val_t xe;
        cord_val_t ye;
        xe = {{(CW-33){xv[32]}}, xv};
        ye = {{(CW-34){yv[33]}}, yv};
        l.org = (xv == 33'sd0) && (yv == 34'sd0);
        if (xv[32]) begin
            l.x = -xe;
            l.y = -ye;
            l.z = yv[33] ? -HALF_TURN : HALF_TURN;
        end else begin
            l.x = xe;
            l.y = ye;
            l.z = '0;
        end
        return l;
    endfunction

    logic [32:0] mag3;
    logic [32:0] np_wide, mp_wide;
    sq_side_t    side3_next;

    assign mag3 = num2_reg[33] ? 33'(-num2_reg) : num2_reg[32:0];

    always_comb begin
        if (n2_reg[32]) begin
            np_wide = n2_reg >> 2;
            mp_wide = mag3 >> 2;
        end else if (n2_reg[31]) begin
            np_wide = n2_reg >> 1;
            mp_wide = mag3 >> 1;
        end else begin
            np_wide = n2_reg;
            mp_wide = mag3;
        end
        side3_next.flags.zero = (n2_reg == 33'd0);
        side3_next.flags.sat  = (mag3 > n2_reg);
        side3_next.flags.neg  = num2_reg[33];
        side3_next.mp         = mp_wide[30:0];
        side3_next.pitch      = atan2_init(py2_reg, px2_reg);
        side3_next.roll       = atan2_init(ry2_reg, rx2_reg);
    end

    logic [30:0] np3_reg;
    sq_side_t    side3_reg;
    logic [61:0] npsq4_reg, mpsq4_reg;
    sq_side_t    side4_reg;
    logic [61:0] rad5_reg;
    sq_side_t    side5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= s_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r1) begin
            sw1_reg <= ww[30:0];
            sx1_reg <= xx[30:0];
            sy1_reg <= yy[30:0];
            sz1_reg <= zz[30:0];
            yw1_reg <= yw;
            xz1_reg <= xz;
            xy1_reg <= xy;
            zw1_reg <= zw;
            yz1_reg <= yz;
            xw1_reg <= xw;
        end
        if (r2) begin
            n2_reg   <= n_next;
            num2_reg <= num_next;
            py2_reg  <= py_next;
            ry2_reg  <= ry_next;
            px2_reg  <= px_next;
            rx2_reg  <= rx_next;
        end
        if (r3) begin
            np3_reg   <= np_wide[30:0];
            side3_reg <= side3_next;
        end
        if (r4) begin
            npsq4_reg <= np3_reg * np3_reg;
            mpsq4_reg <= side3_reg.mp * side3_reg.mp;
            side4_reg <= side3_reg;
        end
        if (r5) begin
            rad5_reg  <= npsq4_reg - mpsq4_reg;
            side5_reg <= side4_reg;
        end
    end

    assign m_valid = v5_reg;
    assign m_rad   = rad5_reg;
    assign m_side  = side5_reg;

endmodule

/* src/qte_isqrt.sv */
// Pipelined floor square root, one result bit per stage, carrying side data alongside.
// Depends on qte_pkg.
module qte_isqrt import qte_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [61:0] s_rad,
    input  sq_side_t    s_side,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_root,
    output sq_side_t    m_side
);

    localparam int NB = 31;

    logic        vld_reg  [NB];
    logic [30:0] root_reg [NB];
    logic [62:0] rem_reg  [NB];
    sq_side_t    side_reg [NB];
    wire  [NB:0] rdy;

    assign rdy[NB]  = m_ready;
    assign s_ready  = rdy[0];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        localparam int B = NB - 1 - k;
        logic        in_v;
        logic [30:0] in_root;
        logic [62:0] in_rem;
        sq_side_t    in_side;
        logic [62:0] trial;
        logic        take;

        if (k == 0) begin : g_first
            assign in_v    = s_valid;
            assign in_root = '0;
            assign in_rem  = {1'b0, s_rad};
            assign in_side = s_side;
        end else begin : g_next
            assign in_v    = vld_reg[k-1];
            assign in_root = root_reg[k-1];
            assign in_rem  = rem_reg[k-1];
            assign in_side = side_reg[k-1];
        end

        // Adding 2^B to the partial root costs 2*root*2^B + 2^(2B) of remainder.
        assign trial = ({32'd0, in_root} << (B + 1)) + (63'd1 << (2 * B));
        assign take  = (in_rem >= trial);
        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= in_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                side_reg[k] <= in_side;
                if (take) begin
                    rem_reg[k]  <= in_rem - trial;
                    root_reg[k] <= in_root | (31'd1 << B);
                end else begin
                    rem_reg[k]  <= in_rem;
                    root_reg[k] <= in_root;
                end
            end
        end
    end

    assign m_valid = vld_reg[NB-1];
    assign m_root  = root_reg[NB-1];
    assign m_side  = side_reg[NB-1];

endmodule

/* src/qte_cordic.sv */
// Three-lane vectoring CORDIC pipeline, one micro-rotation per stage.
// Depends on qte_pkg.
module qte_cordic import qte_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  cord_t s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output cord_t m_data
);

    logic  vld_reg [CORDIC_STAGES];
    cord_t dat_reg [CORDIC_STAGES];
    wire   [CORDIC_STAGES:0] rdy;

    assign rdy[CORDIC_STAGES] = m_ready;
    assign s_ready = rdy[0];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic  in_v;
        cord_t in_d;
        cord_t out_d;

        if (k == 0) begin : g_first
            assign in_v = s_valid;
            assign in_d = s_data;
        end else begin : g_next
            assign in_v = vld_reg[k-1];
            assign in_d = dat_reg[k-1];
        end

        always_comb begin
            out_d       = in_d;
            out_d.yaw   = cordic_step(in_d.yaw, k);
            out_d.pitch = cordic_step(in_d.pitch, k);
            out_d.roll  = cordic_step(in_d.roll, k);
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= in_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                dat_reg[k] <= out_d;
            end
        end
    end

    assign m_valid = vld_reg[CORDIC_STAGES-1];
    assign m_data  = dat_reg[CORDIC_STAGES-1];

endmodule

/* src/qte_back.sv */
// Output stage: sign, saturation and zero handling, rounding to Q7 degrees and clamping.
// Depends on qte_pkg.
module qte_back import qte_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  cord_t      s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output euler_out_t m_data
);

    localparam logic signed [19:0] YAW_LIM = 20'sd11520;
    localparam logic signed [19:0] ATAN_LIM = 20'sd23040;

    // Round half up to Q7 and clamp symmetrically.
    function automatic logic signed [19:0] to_q7(input logic signed [27:0] a,
                                                 input logic signed [19:0] lim);
        logic signed [28:0] t;
        logic signed [19:0] r;
        t = $signed({a[27], a}) + 29'sd256;
        r = t[28:9];
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    logic               valid_reg;
    euler_out_t         data_reg;
    euler_out_t         data_next;
    logic signed [27:0] yaw_a, yaw_s, pitch_a, roll_a;
    logic signed [19:0] yaw_q, pitch_q, roll_q;

    always_comb begin
        yaw_a   = s_data.flags.sat ? {QUARTER_TURN[ZW-1], QUARTER_TURN}
                                   : {s_data.yaw.z[ZW-1], s_data.yaw.z};
        yaw_s   = s_data.flags.neg ? -yaw_a : yaw_a;
        pitch_a = s_data.pitch.org ? 28'sd0 : {s_data.pitch.z[ZW-1], s_data.pitch.z};
        roll_a  = s_data.roll.org ? 28'sd0 : {s_data.roll.z[ZW-1], s_data.roll.z};
        yaw_q   = to_q7(yaw_s, YAW_LIM);
        pitch_q = to_q7(pitch_a, ATAN_LIM);
        roll_q  = to_q7(roll_a, ATAN_LIM);
        if (s_data.flags.zero) begin
            data_next.yaw_deg   = '0;
            data_next.pitch_deg = '0;
            data_next.roll_deg  = '0;
            data_next.status    = STATUS_ZERO;
        end else begin
            data_next.yaw_deg   = yaw_q[14:0];
            data_next.pitch_deg = pitch_q[15:0];
            data_next.roll_deg  = roll_q[15:0];
            data_next.status    = s_data.flags.sat ? STATUS_SAT : STATUS_OK;
        end
    end

    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* dv/quaternion_to_euler_angles_tb.sv */
// Self-checking testbench for the quaternion to Euler angle converter.
// Depends on qte_pkg (request and result structs, status codes) and the converter's RTL.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;
    import qte_pkg::*;

    localparam int STAGES = 16;
    localparam int LATENCY = 37 + STAGES;
    localparam int RAND_ITEMS = 450;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint HALF_Q16 = 180 * 65536;
    localparam longint QUARTER_Q16 = 90 * 65536;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    quat_in_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    euler_out_t m_data;

    // Requests still to be offered, and the angles predicted for accepted ones.
    quat_in_t   pending_quats[$];
    euler_out_t expected_angles[$];

    int     errors = 0;
    longint cycle_count = 0;
    bit     in_taken = 1'b0;     // the offered request was accepted at the last rising edge
    bit     calm_phase = 1'b0;   // no idling on either side while set
    int     hold_off = 0;        // cycles the receiver still refuses results
    bit     hold_off_armed = 1'b0;

    quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // Arctangent of 2^-i in Q16 degrees, the same table the hardware rotates by.
    function automatic longint arctan_step(input int i);
        longint steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                              29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                              57, 29, 14, 7, 4, 2, 1, 0};
        return steps[i];
    endfunction

    // Floor division by a power of two, whatever the sign.
    function automatic longint shift_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(input longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
                r = r + (longint'(1) << b);
        end
        return r;
    endfunction

    // Vectoring rotation for a vector in the right half plane.
    function automatic longint rotate_angle(input longint vx, input longint vy);
        longint acc, dx, dy;
        acc = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = shift_floor(vy, i);
            dy = shift_floor(vx, i);
            if (vy >= 0) begin
                vx += dx; vy -= dy; acc += arctan_step(i);
            end else begin
                vx -= dx; vy += dy; acc -= arctan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint full_angle(input longint vy, input longint vx);
        if (vx == 0 && vy == 0)
            return 0;
        if (vx >= 0)
            return rotate_angle(vx, vy);
        if (vy >= 0)
            return rotate_angle(-vx, -vy) + HALF_Q16;
        return rotate_angle(-vx, -vy) - HALF_Q16;
    endfunction

    function automatic longint round_degrees(input longint a, input longint lim);
        longint r;
        r = shift_floor(a + 256, 9);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic euler_out_t euler_from_quat(input quat_in_t q);
        euler_out_t res;
        longint w, x, y, z, sw, sx, sy, sz, norm, num, mag, np, mp, a;
        int sh;
        w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
        sw = w * w; sx = x * x; sy = y * y; sz = z * z;
        norm = sw + sx + sy + sz;
        res = '0;
        if (norm == 0) begin
            res.status = STATUS_ZERO;
            return res;
        end
        res.status = STATUS_OK;
        num = 2 * (y * w - x * z);
        mag = (num < 0) ? -num : num;
        if (mag > norm) begin
            res.status = STATUS_SAT;
            a = QUARTER_Q16;
        end else begin
            sh = 0;
            while ((norm >> sh) >= (longint'(1) << 31))
                sh++;
            np = norm >> sh;
            mp = mag >> sh;
            a = rotate_angle(root_floor(np * np - mp * mp), mp);
        end
        if (num < 0)
            a = -a;
        res.yaw_deg   = 15'(round_degrees(a, 11520));
        res.pitch_deg = 16'(round_degrees(full_angle(2 * (x * y + z * w), sx - sy - sz + sw),
                                          23040));
        res.roll_deg  = 16'(round_degrees(full_angle(2 * (y * z + x * w), -sx - sy + sz + sw),
                                          23040));
        return res;
    endfunction

    function automatic quat_in_t make_quat(input int w, input int x, input int y, input int z);
        quat_in_t q;
        q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
        return q;
    endfunction

    // A component: mostly within the unit range, sometimes any 16-bit value.
    function automatic int rand_component();
        if ($urandom_range(0, 9) == 0)
            return int'($signed(16'($urandom)));
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // Driver: offers the next queued request on the falling edge, idling at random.
    // A new request is only put up once the one on offer was taken at the last rising edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_quats.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 36)) begin
                    s_data  <= pending_quats.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: random stalls, plus one long hold-off counted here so that the
    // pipeline fills up and pushes back on the sender.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready  <= 1'b0;
            end else if (hold_off_armed) begin
                hold_off_armed <= 1'b0;
                hold_off       <= 3 * LATENCY;
                m_ready        <= 1'b0;
            end else begin
                m_ready <= calm_phase || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    // Monitor: predicts on accepted requests and checks accepted results, both at the rising edge.
    always @(posedge aclk) begin
        euler_out_t want;
        cycle_count <= cycle_count + 1;
        in_taken    <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_angles.push_back(euler_from_quat(s_data));
            if (m_valid && m_ready) begin
                if (expected_angles.size() == 0) begin
                    errors = errors + 1;
                    $display("%t: unexpected result %h", $realtime, m_data);
                end else begin
                    want = expected_angles.pop_front();
                    if (m_data.yaw_deg !== want.yaw_deg) begin
                        errors = errors + 1;
                        $display("%t: yaw expected %0d actual %0d", $realtime,
                                 want.yaw_deg, m_data.yaw_deg);
                    end
                    if (m_data.pitch_deg !== want.pitch_deg) begin
                        errors = errors + 1;
                        $display("%t: pitch expected %0d actual %0d", $realtime,
                                 want.pitch_deg, m_data.pitch_deg);
                    end
                    if (m_data.roll_deg !== want.roll_deg) begin
                        errors = errors + 1;
                        $display("%t: roll expected %0d actual %0d", $realtime,
                                 want.roll_deg, m_data.roll_deg);
                    end
                    if (m_data.status !== want.status) begin
                        errors = errors + 1;
                        $display("%t: status expected %0d actual %0d", $realtime,
                                 want.status, m_data.status);
                    end
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int w, x, y, z;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: the zero quaternion, the identity and its negation, each axis
        // alone at both extremes, a yaw of plus and minus ninety degrees, pitch and roll
        // landing exactly on the half turn, and the most negative 16-bit values.
        pending_quats.push_back(make_quat(0, 0, 0, 0));
        pending_quats.push_back(make_quat(16384, 0, 0, 0));
        pending_quats.push_back(make_quat(-16384, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 16384, 0, 0));
        pending_quats.push_back(make_quat(0, -16384, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 16384, 0));
        pending_quats.push_back(make_quat(0, 0, -16384, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 16384));
        pending_quats.push_back(make_quat(0, 0, 0, -16384));
        pending_quats.push_back(make_quat(11585, 0, 11585, 0));
        pending_quats.push_back(make_quat(11585, 0, -11585, 0));
        pending_quats.push_back(make_quat(11585, 11585, 0, 11585));
        pending_quats.push_back(make_quat(8192, 8192, 8192, 8192));
        pending_quats.push_back(make_quat(-8192, 8192, -8192, 8192));
        pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
        pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_quats.push_back(make_quat(1, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 0, -1));
        pending_quats.push_back(make_quat(0, 1, 1, 0));
        pending_quats.push_back(make_quat(-1, -1, -1, -1));

        // Random requests; the first third runs without any idling, and the long
        // receiver hold-off is armed partway through.
        calm_phase = 1'b1;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            w = rand_component(); x = rand_component();
            y = rand_component(); z = rand_component();
            if ($urandom_range(0, 19) == 0) begin
                w = 0; x = 0; y = 0; z = 0;
            end
            pending_quats.push_back(make_quat(w, x, y, z));
        end
        wait (pending_quats.size() < 2 * RAND_ITEMS / 3);
        @(negedge aclk);
        calm_phase = 1'b0;
        hold_off_armed = 1'b1;

        // Every request has been taken once the queue is empty and nothing is on offer;
        // a lost result keeps the prediction queue from draining and runs into the limit.
        wait (pending_quats.size() == 0 && !s_valid);
        wait (expected_angles.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
